/* design/apt_pkg.sv */
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants of the access point tracking table.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W   = 48;
    localparam int CHAN_W   = 4;
    localparam int LEVEL_W  = 8;
    localparam int VER_W    = 8;
    localparam int METH_W   = 16;
    localparam int HITS_W   = 32;
    localparam int TOTAL_W  = 32;
    localparam int RDIDX_W  = 6;
    localparam int SLOT_W   = 6;
    localparam int USED_W   = 7;
    localparam int CMP_W    = (IDX_W > RDIDX_W) ? IDX_W : RDIDX_W;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        ACT_OBSERVE = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STS_INSERTED = 3'd0,
        STS_UPDATED  = 3'd1,
        STS_FULL     = 3'd2,
        STS_CLEARED  = 3'd3,
        STS_READ_OK  = 3'd4,
        STS_RANGE    = 3'd5
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [CHAN_W-1:0]  chan;
        logic [LEVEL_W-1:0] level;
        logic [VER_W-1:0]   ver;
        logic               locked;
        logic               configured;
        logic [METH_W-1:0]  methods;
        logic [HITS_W-1:0]  hits;
    } t_entry;

endpackage

`default_nettype wire

/* design/apt_cell.sv */
// ----------------------------------------------------------------------------
// apt_cell
// One table entry of the rotating chain; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_cell
    import apt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_shift,
    input  wire t_entry i_entry,
    output t_entry      o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

/* design/access_point_tracking_table_core.sv */
// ----------------------------------------------------------------------------
// access_point_tracking_table_core
// Table of seen access points keyed by address, with observe, clear and read.
// ----------------------------------------------------------------------------
// Usage: items enter on the slave stream (i_s_*); tuser carries the action
// (observe, clear, read). Each item with a defined action gives one result
// item on the master stream (o_m_*), whose tuser carries the status.
// The entries live in a ring of TABLE_ENTRIES cells that rotates by one
// place per cycle (but for a last step held by a stalled output) past a
// single head stage, which compares the address, updates or inserts an
// entry, or picks out the entry asked for by a read. Every item makes one
// full turn of the ring: its result is loaded as the turn ends, and the
// next item is taken in the cycle after, never before the turn is through.
// The result sits in an output register, so the next item runs while it
// waits; if the receiver still stalls when the following turn ends, the
// ring holds its last step until the output register frees up.
// An item with the unused action code is taken and dropped without result.
// Reset clears the entry count, the frame total and the handshake state;
// the entry contents need no clearing because only used entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module access_point_tracking_table_core
    import apt_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    // ap_address, rx_channel, signal_level, wps_version, is_configured,
    // is_locked, method_mask, read_index
    input  wire [S_TDATA_W-1:0]  i_s_tdata,
    // action
    input  wire [S_TUSER_W-1:0]  i_s_tuser,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    // slot, entries_used, frames_total, out_address, out_channel,
    // best_signal, out_version, out_configured, out_locked, out_methods,
    // hit_count
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // status
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    // Control state.
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_used;
    logic [TOTAL_W-1:0] r_total;
    logic               r_hit, r_new, r_got;
    logic               r_out_valid;

    // Item held during its turn.
    t_action            r_act;
    logic [ADDR_W-1:0]  r_addr;
    logic [CHAN_W-1:0]  r_chan;
    logic [LEVEL_W-1:0] r_level;
    logic [VER_W-1:0]   r_ver;
    logic               r_cfg, r_lock;
    logic [METH_W-1:0]  r_meth;
    logic [RDIDX_W-1:0] r_rd_idx;

    t_entry             r_cap;
    logic [IDX_W-1:0]   r_slot;

    // Output register.
    t_status            r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [USED_W-1:0]  r_out_used;
    logic [TOTAL_W-1:0] r_out_total;
    t_entry             r_out_ent;

    logic               w_accept, w_shift, w_last, w_finish, w_out_free;
    t_action            w_in_act;
    t_entry             w_chain [TABLE_ENTRIES];
    t_entry             w_head, w_head_mod, w_cap_f;
    logic               w_in_used, w_match, w_ins, w_rd;
    logic               w_hit_f, w_new_f, w_got_f;
    logic [IDX_W-1:0]   w_slot_f;
    logic [CNT_W-1:0]   w_used_f;
    t_status            w_status_f;
    logic [SLOT_W-1:0]  w_out_slot_f;

    assign w_in_act   = t_action'(i_s_tuser);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last     = (r_idx == IDX_W'(TABLE_ENTRIES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_in_act != ACT_NONE) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_tready = 1'b0;
        w_shift    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_SCAN: w_shift    = !w_last || w_out_free;
            default: o_s_tready = 1'b0;
        endcase
    end

    assign w_finish = w_shift && w_last;

    // The ring: cell k takes cell k+1, the last cell takes the head's result.
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        if (k == TABLE_ENTRIES - 1) begin : g_tail
            apt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_head_mod),
                .o_entry (w_chain[k])
            );
        end else begin : g_body
            apt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_chain[k+1]),
                .o_entry (w_chain[k])
            );
        end
    end

    // Head stage: cell 0 holds the entry whose index is r_idx.
    assign w_head    = w_chain[0];
    assign w_in_used = (CNT_W'(r_idx) < r_used);
    assign w_match   = (r_act == ACT_OBSERVE) && !r_hit && w_in_used &&
                       (w_head.addr == r_addr);
    // No earlier hit and the index reached the first free place: append here.
    assign w_ins     = (r_act == ACT_OBSERVE) && !r_hit &&
                       (CNT_W'(r_idx) == r_used);
    assign w_rd      = (r_act == ACT_READ) && w_in_used &&
                       (CMP_W'(r_rd_idx) == CMP_W'(r_idx));

    always_comb begin
        w_head_mod = w_head;
        if (w_ins) begin
            w_head_mod.addr  = r_addr;
            w_head_mod.chan  = r_chan;
            w_head_mod.level = r_level;
            w_head_mod.hits  = HITS_W'(1);
        end else if (w_match) begin
            if ($signed(r_level) > $signed(w_head.level)) begin
                w_head_mod.level = r_level;
            end
            w_head_mod.hits = w_head.hits + HITS_W'(1);
        end
        if (w_ins || w_match) begin
            w_head_mod.ver        = r_ver;
            w_head_mod.configured = r_cfg;
            w_head_mod.locked     = r_lock;
            w_head_mod.methods    = r_meth;
        end
    end

    // Result as it stands after this step.
    always_comb begin
        w_hit_f  = r_hit || w_match;
        w_new_f  = r_new || w_ins;
        w_got_f  = r_got || w_rd;
        w_cap_f  = r_cap;
        w_slot_f = r_slot;
        if (w_match || w_ins) begin
            w_cap_f  = w_head_mod;
            w_slot_f = r_idx;
        end else if (w_rd) begin
            w_cap_f  = w_head;
            w_slot_f = r_idx;
        end
        w_used_f = r_used + CNT_W'(w_new_f);

        w_status_f   = STS_FULL;
        w_out_slot_f = '0;
        case (r_act)
            ACT_OBSERVE: begin
                if (w_new_f) begin
                    w_status_f   = STS_INSERTED;
                    w_out_slot_f = SLOT_W'(w_slot_f);
                end else if (w_hit_f) begin
                    w_status_f   = STS_UPDATED;
                    w_out_slot_f = SLOT_W'(w_slot_f);
                end else begin
                    w_status_f = STS_FULL;
                end
            end
            ACT_CLEAR: w_status_f = STS_CLEARED;
            ACT_READ: begin
                w_status_f   = w_got_f ? STS_READ_OK : STS_RANGE;
                w_out_slot_f = SLOT_W'(r_rd_idx);
            end
            default: w_status_f = STS_FULL;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_hit       <= 1'b0;
            r_new       <= 1'b0;
            r_got       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_hit <= 1'b0;
                r_new <= 1'b0;
                r_got <= 1'b0;
                if (w_in_act == ACT_OBSERVE) begin
                    r_total <= r_total + TOTAL_W'(1);
                end else if (w_in_act == ACT_CLEAR) begin
                    r_total <= '0;
                    r_used  <= '0;
                end
            end
            if (w_shift) begin
                r_idx <= w_last ? '0 : r_idx + IDX_W'(1);
                r_hit <= w_hit_f;
                r_new <= w_new_f;
                r_got <= w_got_f;
            end
            if (w_finish) begin
                r_used      <= w_used_f;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act    <= w_in_act;
            r_addr   <= i_s_tdata[47:0];
            r_chan   <= i_s_tdata[51:48];
            r_level  <= i_s_tdata[59:52];
            r_ver    <= i_s_tdata[67:60];
            r_cfg    <= i_s_tdata[68];
            r_lock   <= i_s_tdata[69];
            r_meth   <= i_s_tdata[85:70];
            r_rd_idx <= i_s_tdata[91:86];
            r_cap    <= '0;
            r_slot   <= '0;
        end else if (w_shift) begin
            r_cap  <= w_cap_f;
            r_slot <= w_slot_f;
        end
        if (w_finish) begin
            r_out_status <= w_status_f;
            r_out_slot   <= w_out_slot_f;
            r_out_used   <= USED_W'(w_used_f);
            r_out_total  <= r_total;
            r_out_ent    <= w_cap_f;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {5'd0,
                         r_out_ent.hits,
                         r_out_ent.methods,
                         r_out_ent.locked,
                         r_out_ent.configured,
                         r_out_ent.ver,
                         r_out_ent.level,
                         r_out_ent.chan,
                         r_out_ent.addr,
                         r_out_total,
                         r_out_used,
                         r_out_slot};

    // The entry count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // The ring steps one index per shift within a turn.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && !w_last) |=> (r_idx == $past(r_idx) + IDX_W'(1)))
        else $error("ring index out of step");

    // A result only appears at the end of a turn.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_SCAN && w_last))
        else $error("result loaded outside the end of a turn");

    // An item never both hits and inserts.
    a_hit_or_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_hit && r_new))
        else $error("item both hit and inserted");

endmodule

`default_nettype wire
